### design/tts_pkg.sv
// Shared types and codes for the task table scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package tts_pkg;

  localparam int SlotsDef = 16;
  localparam int IdWidthDef = 16;

  // opcodes
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_FORK   = 3'd1;
  localparam logic [2:0] OP_EXIT   = 3'd2;
  localparam logic [2:0] OP_WAIT   = 3'd3;
  localparam logic [2:0] OP_SCHED  = 3'd4;

  // answer codes
  localparam logic [2:0] RS_OK      = 3'd0;
  localparam logic [2:0] RS_FULL    = 3'd1;
  localparam logic [2:0] RS_NOCUR   = 3'd2;
  localparam logic [2:0] RS_BLOCKED = 3'd3;
  localparam logic [2:0] RS_NOSW    = 3'd4;

  // slot states
  localparam logic [2:0] SL_UNUSED  = 3'd0;
  localparam logic [2:0] SL_RUNNING = 3'd1;
  localparam logic [2:0] SL_READY   = 3'd2;
  localparam logic [2:0] SL_BLOCKED = 3'd3;
  localparam logic [2:0] SL_ZOMBIE  = 3'd4;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_ZERO, PTR_CUR, PTR_BASE, PTR_INC, PTR_BEST
  } ptr_sel_e;

  typedef struct packed {
    logic       load;
    logic       set_st;
    logic [2:0] st_code;
    ptr_sel_e   ptr_sel;
    logic       wr_new;
    logic       wr_exit;
    logic       wr_wake;
    logic       wr_reap;
    logic       wr_block;
    logic       wr_yield;
    logic       wr_run;
    logic       run_report;
    logic       save_best;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic hc;
    logic en;
    logic is_free;
    logic is_ready;
    logic is_blocked;
    logic id_hit;
    logic par_nz;
    logic zomb_child;
    logic ptr_is_cur;
    logic out_free;
  } dp_stat_t;

endpackage

### design/task_table_scheduler.sv
// Task table scheduler: one operation per beat, one result beat each.
// Timing, accept edge to result valid: shortest for a rejected op, longest
// for exit or a blocking wait (two slot scans, one slot per cycle).
// Throughput: one operation at a time; a new beat is taken once the result
// is registered, while that result may still wait on the output.
// Reset: asynchronous, active low; all slots unused, no current task, id counter 1.
`timescale 1ns / 1ps
module task_table_scheduler #(
  parameter int SLOTS = tts_pkg::SlotsDef,
  parameter int ID_WIDTH = tts_pkg::IdWidthDef,
  localparam int OW = ((3 + 2 * ID_WIDTH + 33) + 7) / 8 * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [39:0]   s_tdata,   // opcode[2:0], exit_value[34:3], zero pad
  output logic          m_tvalid,
  input  logic          m_tready,
  // status[2:0], task_id, child_exit_value (32), running_id, switched, zero pad
  output logic [OW-1:0] m_tdata,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import tts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     en, cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, en} : 32'd0;

  tts_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i, .rst_ni,
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .opcode_i   (s_tdata[2:0]),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tts_datapath #(.SLOTS(SLOTS), .ID_WIDTH(ID_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .stat_o       (stat),
    .exit_value_i (s_tdata[34:3]),
    .cfg_we_i     (cfg_we),
    .cfg_wd_i     (pwdata[0]),
    .en_o         (en),
    .m_tready_i   (m_tready),
    .m_tvalid_o   (m_tvalid),
    .m_tdata_o    (m_tdata)
  );

endmodule

### design/tts_datapath.sv
// Datapath: slot tables, current task, id counter, config and result register.
// Depends on tts_pkg; driven by tts_ctrl commands.
`timescale 1ns / 1ps
module tts_datapath #(
  parameter int SLOTS = tts_pkg::SlotsDef,
  parameter int ID_WIDTH = tts_pkg::IdWidthDef,
  localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int OW = ((3 + 2 * ID_WIDTH + 33) + 7) / 8 * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tts_pkg::dp_cmd_t    cmd_i,
  output tts_pkg::dp_stat_t   stat_o,
  input  logic [31:0]         exit_value_i,
  input  logic                cfg_we_i,
  input  logic                cfg_wd_i,
  output logic                en_o,
  input  logic                m_tready_i,
  output logic                m_tvalid_o,
  output logic [OW-1:0]       m_tdata_o
);
  import tts_pkg::*;

  localparam logic [PW-1:0] LastSlot = PW'(SLOTS - 1);

  logic [2:0]          slot_st_q [SLOTS];
  logic [ID_WIDTH-1:0] slot_id_q [SLOTS];
  logic [ID_WIDTH-1:0] slot_par_q [SLOTS];
  logic [31:0]         slot_xv_q [SLOTS];

  logic [PW-1:0]       ptr_q, ptr_d, best_q, cur_q;
  logic                cur_valid_q, en_q;
  logic [2:0]          cur_st_q;
  logic [ID_WIDTH-1:0] cur_id_q, id_ctr_q, id_ctr_inc, par_q;
  logic [31:0]         xv_q, cev_q;
  logic [ID_WIDTH-1:0] tid_q;
  logic [2:0]          rs_q;
  logic                sw_q;
  logic                out_v_q;
  logic [OW-1:0]       out_q;

  logic [2:0]          rd_st;
  logic [ID_WIDTH-1:0] rd_id, rd_par;
  logic                hc, st_we;
  logic [2:0]          st_wd;

  assign rd_st  = slot_st_q[ptr_q];
  assign rd_id  = slot_id_q[ptr_q];
  assign rd_par = slot_par_q[ptr_q];
  assign hc     = cur_valid_q && (cur_st_q != SL_UNUSED);
  assign id_ctr_inc = id_ctr_q + 1'b1;

  assign stat_o.hc         = hc;
  assign stat_o.en         = en_q;
  assign stat_o.is_free    = (rd_st == SL_UNUSED);
  assign stat_o.is_ready   = (rd_st == SL_READY);
  assign stat_o.is_blocked = (rd_st == SL_BLOCKED);
  assign stat_o.id_hit     = (rd_st != SL_UNUSED) && (rd_id == par_q);
  assign stat_o.par_nz     = (rd_par != '0);
  assign stat_o.zomb_child = (rd_st == SL_ZOMBIE) && (rd_par == cur_id_q);
  assign stat_o.ptr_is_cur = (ptr_q == cur_q);
  assign stat_o.out_free   = !out_v_q || m_tready_i;

  assign en_o       = en_q;
  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_q;

  always_comb begin
    st_we = 1'b1;
    st_wd = SL_READY;
    priority if (cmd_i.wr_new || cmd_i.wr_wake) begin
      st_wd = SL_READY;
    end else if (cmd_i.wr_exit) begin
      st_wd = SL_ZOMBIE;
    end else if (cmd_i.wr_reap) begin
      st_wd = SL_UNUSED;
    end else if (cmd_i.wr_block) begin
      st_wd = SL_BLOCKED;
    end else if (cmd_i.wr_yield && rd_st == SL_RUNNING) begin
      st_wd = SL_READY;
    end else if (cmd_i.wr_run) begin
      st_wd = SL_RUNNING;
    end else begin
      st_we = 1'b0;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    unique case (cmd_i.ptr_sel)
      PTR_HOLD: ptr_d = ptr_q;
      PTR_ZERO: ptr_d = '0;
      PTR_CUR:  ptr_d = cur_q;
      PTR_BASE: ptr_d = !hc ? '0 : ((cur_q == LastSlot) ? '0 : cur_q + 1'b1);
      PTR_INC:  ptr_d = (ptr_q == LastSlot) ? '0 : ptr_q + 1'b1;
      PTR_BEST: ptr_d = best_q;
      default:  ptr_d = ptr_q;
    endcase
  end

  // slot states need a known reset; the other tables are read only once filled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_st_q[i] <= SL_UNUSED;
      ptr_q       <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      cur_st_q    <= SL_UNUSED;
      id_ctr_q    <= ID_WIDTH'(1);
      en_q        <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      if (cfg_we_i) en_q <= cfg_wd_i;
      if (st_we) slot_st_q[ptr_q] <= st_wd;
      if (cmd_i.wr_run) begin
        cur_q       <= ptr_q;
        cur_valid_q <= 1'b1;
        cur_st_q    <= SL_RUNNING;
      end else if (st_we && ptr_q == cur_q) begin
        cur_st_q <= st_wd;
      end
      if (cmd_i.wr_new) id_ctr_q <= (id_ctr_inc == '0) ? ID_WIDTH'(1) : id_ctr_inc;
      if (cmd_i.emit) out_v_q <= 1'b1;
      else if (m_tready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_new) begin
      slot_id_q[ptr_q]  <= id_ctr_q;
      slot_par_q[ptr_q] <= hc ? cur_id_q : '0;
    end
    if (cmd_i.wr_exit) begin
      slot_xv_q[ptr_q] <= xv_q;
      par_q            <= rd_par;
    end
    // a new task landing in the current slot becomes the current task
    if (cmd_i.wr_run) cur_id_q <= rd_id;
    else if (cmd_i.wr_new && ptr_q == cur_q) cur_id_q <= id_ctr_q;
    if (cmd_i.save_best) best_q <= ptr_q;
    if (cmd_i.load) begin
      xv_q  <= exit_value_i;
      rs_q  <= cmd_i.set_st ? cmd_i.st_code : RS_NOSW;
      tid_q <= '0;
      cev_q <= '0;
      sw_q  <= 1'b0;
    end else begin
      if (cmd_i.set_st) rs_q <= cmd_i.st_code;
      if (cmd_i.wr_new) tid_q <= id_ctr_q;
      if (cmd_i.wr_exit) tid_q <= cur_id_q;
      if (cmd_i.wr_reap) begin
        tid_q <= rd_id;
        cev_q <= slot_xv_q[ptr_q];
      end
      if (cmd_i.wr_run) begin
        sw_q <= 1'b1;
        if (cmd_i.run_report) tid_q <= rd_id;
      end
    end
    if (cmd_i.emit) begin
      out_q <= OW'({sw_q, (hc ? cur_id_q : '0), cev_q, tid_q, rs_q});
    end
  end

endmodule

### design/tts_ctrl.sv
// Controller: sequences each operation over the datapath, mostly as slot scans.
// Depends on tts_pkg; drives tts_datapath through dp_cmd_t.
`timescale 1ns / 1ps
module tts_ctrl #(
  parameter int SLOTS = tts_pkg::SlotsDef,
  localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [2:0]        opcode_i,
  input  tts_pkg::dp_stat_t stat_i,
  output tts_pkg::dp_cmd_t  cmd_o
);
  import tts_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FREE  = 4'd1;
  localparam logic [3:0] S_EXIT  = 4'd2;
  localparam logic [3:0] S_LOOK  = 4'd3;
  localparam logic [3:0] S_ZSCAN = 4'd4;
  localparam logic [3:0] S_BLOCK = 4'd5;
  localparam logic [3:0] S_SBASE = 4'd6;
  localparam logic [3:0] S_SSCAN = 4'd7;
  localparam logic [3:0] S_YIELD = 4'd8;
  localparam logic [3:0] S_RUN   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [PW-1:0] LastCnt = PW'(SLOTS - 1);

  logic [3:0]    state_q, state_d;
  logic [PW-1:0] cnt_q, cnt_d;
  logic          sched_q, sched_d;
  logic          last;

  assign s_tready_o = (state_q == S_IDLE);
  assign last = (cnt_q == LastCnt);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sched_d = sched_q;
    cmd_o   = '0;
    cmd_o.ptr_sel = PTR_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          sched_d    = (opcode_i == OP_SCHED);
          unique case (opcode_i)
            OP_CREATE: begin
              cmd_o.ptr_sel = PTR_ZERO;
              state_d = S_FREE;
            end
            OP_FORK, OP_WAIT: begin
              if (!stat_i.hc) begin
                state_d = S_DONE;
              end else begin
                cmd_o.ptr_sel = PTR_ZERO;
                state_d = (opcode_i == OP_FORK) ? S_FREE : S_ZSCAN;
              end
            end
            OP_EXIT: begin
              if (!stat_i.hc) begin
                state_d = S_DONE;
              end else begin
                cmd_o.ptr_sel = PTR_CUR;
                state_d = S_EXIT;
              end
            end
            OP_SCHED: state_d = S_SBASE;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_FREE: begin
        if (stat_i.is_free) begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = RS_OK;
          state_d = S_DONE;
        end else if (last) begin
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = RS_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.ptr_sel = PTR_INC;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_EXIT: begin
        cmd_o.wr_exit = 1'b1;
        cmd_o.set_st  = 1'b1;
        cmd_o.st_code = RS_OK;
        if (stat_i.par_nz) begin
          cmd_o.ptr_sel = PTR_ZERO;
          state_d = S_LOOK;
        end else begin
          state_d = S_SBASE;
        end
      end
      S_LOOK: begin
        // first used slot with the parent id decides
        if (stat_i.id_hit) begin
          cmd_o.wr_wake = stat_i.is_blocked;
          state_d = S_SBASE;
        end else if (last) begin
          state_d = S_SBASE;
        end else begin
          cmd_o.ptr_sel = PTR_INC;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ZSCAN: begin
        if (stat_i.zomb_child) begin
          cmd_o.wr_reap = 1'b1;
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = RS_OK;
          state_d = S_DONE;
        end else if (last) begin
          cmd_o.ptr_sel = PTR_CUR;
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = RS_BLOCKED;
          state_d = S_BLOCK;
        end else begin
          cmd_o.ptr_sel = PTR_INC;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_BLOCK: begin
        cmd_o.wr_block = 1'b1;
        state_d = S_SBASE;
      end
      S_SBASE: begin
        if (!stat_i.en) begin
          state_d = S_DONE;
        end else begin
          cmd_o.ptr_sel = PTR_BASE;
          cnt_d = '0;
          state_d = S_SSCAN;
        end
      end
      S_SSCAN: begin
        if (stat_i.is_ready) begin
          if (stat_i.hc && stat_i.ptr_is_cur) begin
            state_d = S_DONE;
          end else begin
            cmd_o.save_best = 1'b1;
            cmd_o.ptr_sel   = PTR_CUR;
            state_d = S_YIELD;
          end
        end else if (last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.ptr_sel = PTR_INC;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_YIELD: begin
        cmd_o.wr_yield = stat_i.hc;
        cmd_o.ptr_sel  = PTR_BEST;
        state_d = S_RUN;
      end
      S_RUN: begin
        cmd_o.wr_run     = 1'b1;
        cmd_o.run_report = sched_q;
        cmd_o.set_st     = sched_q;
        cmd_o.st_code    = RS_OK;
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees up
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_IDLE && s_tvalid_i && !stat_i.hc &&
        (opcode_i == OP_FORK || opcode_i == OP_EXIT || opcode_i == OP_WAIT)) begin
      cmd_o.set_st  = 1'b1;
      cmd_o.st_code = RS_NOCUR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sched_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sched_q <= sched_d;
    end
  end

endmodule

### design/tts_checker.sv
// Port-level checks for task_table_scheduler, attached by bind.
// Depends on tts_pkg and the top level's ports.
`timescale 1ns / 1ps
module tts_port_checks #(
  parameter int ID_WIDTH = tts_pkg::IdWidthDef,
  localparam int OW = ((3 + 2 * ID_WIDTH + 33) + 7) / 8 * 8
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_tvalid,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [OW-1:0] m_tdata
);
  import tts_pkg::*;

  // hold a stalled result beat
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped while stalled");

  // any status other than RS_OK (failed, blocked, no switch) reports no task id
  a_tid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[2:0] != RS_OK |-> m_tdata[3 +: ID_WIDTH] == '0)
    else $error("task id on failed operation");

  // a switch always leaves a running task
  a_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[35 + 2 * ID_WIDTH] |-> m_tdata[35 + ID_WIDTH +: ID_WIDTH] != '0)
    else $error("switch without running task");

  // after an accepted beat, the input is never ready again in the very next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

endmodule

bind task_table_scheduler tts_port_checks #(.ID_WIDTH(ID_WIDTH)) u_tts_checker (
  .clk_i, .rst_ni, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
